@@ rtl/mrbf_pkg.sv @@
// Shared types and status codes for the multi-reader broadcast FIFO.
`timescale 1ns / 1ps
package mrbf_pkg;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_DATA = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [63:0] record_in;
      logic        reader_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] record_out;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit_insert;
      logic commit_read;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_is_read;
   } ctl_status_type;

endpackage

@@ rtl/mrbf_datapath.sv @@
// Datapath: record store, queue pointers, reader flags and result register.
`timescale 1ns / 1ps
module mrbf_datapath #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int NUM_READERS  = 2,
   parameter int RECORD_WIDTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mrbf_pkg::req_type       req_item,
   input  mrbf_pkg::ctl_cmd_type   ctl_cmd,
   output mrbf_pkg::ctl_status_type ctl_status,
   output logic                    rsp_valid,
   output mrbf_pkg::rsp_type       rsp_item
);
   import mrbf_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [RECORD_WIDTH-1:0] mem [QUEUE_DEPTH];

   req_type                 req_ff;
   logic [RECORD_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [IDX_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [NUM_READERS-1:0]  seen_ff, seen_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    full, empty, reader_ok, seen_hit, do_write;
   logic [NUM_READERS-1:0]  rd_mask, seen_next;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign reader_ok = ({31'd0, req_ff.reader_id} < NUM_READERS);
   assign rd_mask   = reader_ok ? (NUM_READERS'(1) << req_ff.reader_id) : '0;
   assign seen_hit  = |(seen_ff & rd_mask);
   assign seen_next = seen_ff | rd_mask;
   assign do_write  = ctl_cmd.commit_insert && !full;

   assign ctl_status.req_is_read = (req_ff.cmd == CMD_READ);

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      seen_in      = seen_ff;
      rsp_valid_in = ctl_cmd.commit_insert || ctl_cmd.commit_read;
      rsp_in       = rsp_ff;
      if (ctl_cmd.commit_insert) begin
         rsp_in.record_out = '0;
         if (full) begin
            rsp_in.status = ST_FULL;
         end else begin
            rsp_in.status = ST_OK;
            tail_in  = (tail_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + IDX_W'(1);
            count_in = count_ff + CNT_W'(1);
         end
      end else if (ctl_cmd.commit_read) begin
         if (empty || !reader_ok || seen_hit) begin
            rsp_in.status     = ST_NO_DATA;
            rsp_in.record_out = '0;
         end else begin
            rsp_in.status     = ST_OK;
            rsp_in.record_out = 64'(rd_data_ff);
            if (&seen_next) begin
               // last reader took the head: pop it
               head_in  = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
               count_in = count_ff - CNT_W'(1);
               seen_in  = '0;
            end else begin
               seen_in = seen_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (ctl_cmd.capture) begin
         req_ff     <= req_item;
         rd_data_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[tail_ff] <= req_ff.record_in[RECORD_WIDTH-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ rtl/mrbf_ctrl.sv @@
// Controller: sequences capture and commit of one item at a time.
`timescale 1ns / 1ps
module mrbf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  mrbf_pkg::ctl_status_type ctl_status,
   output mrbf_pkg::ctl_cmd_type    ctl_cmd
);
   import mrbf_pkg::*;

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_COMMIT = 1'b1;

   logic state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl_cmd.capture = 1'b1;
               state_in        = S_COMMIT;
            end
         end
         S_COMMIT: begin
            ctl_cmd.commit_read   = ctl_status.req_is_read;
            ctl_cmd.commit_insert = !ctl_status.req_is_read;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ rtl/multi_reader_broadcast_fifo_unit.sv @@
// Top level of the multi-reader broadcast FIFO.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive req_item and raise start; the item is taken at a
//   clock edge with start high and busy low. cmd INSERT appends record_in at
//   the tail (status FULL when the store holds QUEUE_DEPTH records); cmd READ
//   lets reader_id take the head record once. The head pops after every
//   reader has taken it. A read with nothing for that reader answers
//   NO_DATA at once.
//   Result channel: rsp_valid strobes for one cycle with rsp_item; the
//   receiver cannot hold it off, so it must take it in that cycle.
//   Timing: capture cycle (head slot read from the store), commit cycle
//   (pointers, flags and store updated), result on the following cycle.
//   busy is high in the commit cycle, so a new item is taken only after the
//   capture/commit sequence of the controller for the last one is done.
//   Reset clears pointers, count, reader flags and the controller; store
//   contents are undefined until written and never reach rsp_item before that.
module multi_reader_broadcast_fifo_unit #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int NUM_READERS  = 2,
   parameter int RECORD_WIDTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mrbf_pkg::req_type req_item,
   output logic              rsp_valid,
   output mrbf_pkg::rsp_type rsp_item
);
   import mrbf_pkg::*;

   ctl_cmd_type    ctl_cmd;
   ctl_status_type ctl_status;

   // controller: one item in flight
   mrbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .ctl_status (ctl_status),
      .ctl_cmd    (ctl_cmd)
   );

   // datapath: store, pointers, reader flags, result register
   mrbf_datapath #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .NUM_READERS  (NUM_READERS),
      .RECORD_WIDTH (RECORD_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .ctl_cmd    (ctl_cmd),
      .ctl_status (ctl_status),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

endmodule
